[src/mce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mce_pkg: shared types, constants and code table of the Morse element encoder
// Holds the element kinds, the character codes that steer the encoder, the
// job record passed from the front end to the sequencer and the code lookup.
// ----------------------------------------------------------------------------
package mce_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DOT_W      = 16;
  localparam int unsigned DUR_W      = 19;
  localparam int unsigned LEN_W      = 3;
  localparam int unsigned PAT_W      = 6;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned AS_DEPTH   = 2;
  localparam int unsigned AS_ADDR_W  = 1;
  localparam logic [CNT_W-1:0] MAX_ELEMS = 4'd12;

  localparam logic [DOT_W-1:0]  DOT_TICKS_RESET = 16'd20;
  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_PERIOD = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOW_Z  = 8'h7A;

  typedef enum logic [2:0] {
    KIND_DOT    = 3'd0,
    KIND_DASH   = 3'd1,
    KIND_INTRA  = 3'd2,
    KIND_LETTER = 3'd3,
    KIND_WORD   = 3'd4
  } elem_kind_t;

  // symbol count and pattern, first symbol in the highest used bit, 1 = dash
  localparam logic [LEN_W-1:0] LETTER_LEN [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [PAT_W-1:0] LETTER_BITS [26] = '{
    6'd1, 6'd8, 6'd10, 6'd4, 6'd0, 6'd2, 6'd6, 6'd0, 6'd0, 6'd7, 6'd5, 6'd4, 6'd3,
    6'd2, 6'd7, 6'd6, 6'd13, 6'd2, 6'd0, 6'd1, 6'd1, 6'd1, 6'd3, 6'd9, 6'd11, 6'd12
  };
  localparam logic [PAT_W-1:0] DIGIT_BITS [10] = '{
    6'd31, 6'd15, 6'd7, 6'd3, 6'd1, 6'd0, 6'd16, 6'd24, 6'd28, 6'd30
  };

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] bits;
  } code_t;

  // one character as seen by the sequencer
  typedef struct packed {
    logic             letter;  // lead letter gap
    logic             word;    // word gap
    logic [LEN_W-1:0] len;     // symbol count
    logic [PAT_W-1:0] pat;     // symbols, first one in the top bit
    logic [CNT_W-1:0] total;   // elements to send
  } char_job_t;

  function automatic code_t code_lookup(input logic [CHAR_W-1:0] c);
    code_t             res;
    logic [CHAR_W-1:0] off;
    res = '0;
    off = '0;
    if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
      off       = c - CHAR_LOW_A;
      res.found = 1'b1;
      res.len   = LETTER_LEN[off[4:0]];
      res.bits  = LETTER_BITS[off[4:0]];
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      off       = c - CHAR_ZERO;
      res.found = 1'b1;
      res.len   = 3'd5;
      res.bits  = DIGIT_BITS[off[3:0]];
    end else if (c == CHAR_COMMA) begin
      res.found = 1'b1;
      res.len   = 3'd6;
      res.bits  = 6'd51;
    end else if (c == CHAR_PERIOD) begin
      res.found = 1'b1;
      res.len   = 3'd6;
      res.bits  = 6'd21;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[src/mce_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mce_ram: generic single-write, single-read RAM
// One write port and one read port with read data registered.
// ----------------------------------------------------------------------------
module mce_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  wire                                         clk,
  input  wire                                         wr_en,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]                            wr_data,
  input  wire                                         rd_en,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[src/mce_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mce_front: input stage and after-space state memory
// Takes one character, reads the after-space flag from the state RAM,
// decodes the Morse pattern and hands a job to the sequencer, writing the
// new flag back when the job leaves.
// ----------------------------------------------------------------------------
module mce_front (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [mce_pkg::CHAR_W-1:0] in_char,
  output logic                       job_valid,
  input  wire                        job_ready,
  output mce_pkg::char_job_t         job
);
  import mce_pkg::*;

  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              in_take;
  logic              job_take;
  logic              as_rdata;
  logic              as_wdata;
  logic              as_init;     // entry has been written since reset
  logic              rd_init;     // entry state sampled with the read
  logic              byp;         // write landed at the read edge
  logic              byp_data;
  logic              after_space;
  logic              is_space;
  logic              is_eol;
  code_t             code;
  logic [PAT_W-1:0]  pat;
  logic [CNT_W-1:0]  sym_elems;

  assign in_take  = in_valid && in_ready;
  assign job_take = s1_valid && job_ready;
  assign in_ready = !s1_valid || job_ready;
  assign as_wdata = (s1_char == CHAR_SPACE);

  // hold one request in the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_take) begin
      s1_char <= in_char;
    end
  end

  // state RAM: read on accept, write back when the job leaves
  mce_ram #(
    .WIDTH(1),
    .DEPTH(AS_DEPTH)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (job_take),
    .wr_addr ({AS_ADDR_W{1'b0}}),
    .wr_data (as_wdata),
    .rd_en   (in_take),
    .rd_addr ({AS_ADDR_W{1'b0}}),
    .rd_data (as_rdata)
  );

  // track first write and forward a write that meets the read
  always_ff @(posedge clk) begin
    if (rst) begin
      as_init <= 1'b0;
    end else if (job_take) begin
      as_init <= 1'b1;
    end
    if (in_take) begin
      rd_init  <= as_init;
      byp      <= job_take;
      byp_data <= as_wdata;
    end
  end

  assign after_space = byp ? byp_data : (rd_init && as_rdata);

  // decode the held character
  always_comb begin
    is_space  = (s1_char == CHAR_SPACE);
    is_eol    = (s1_char == CHAR_CR) || (s1_char == CHAR_LF);
    code      = code_lookup(s1_char);
    pat       = code.bits << (3'd6 - code.len);
    sym_elems = (code.len != '0) ? ({code.len, 1'b0} - 4'd1) : 4'd0;
    job.letter = !is_eol && !is_space && !after_space;
    job.word   = is_space;
    job.len    = code.len;
    job.pat    = pat;
    job.total  = {3'b0, job.letter} + {3'b0, job.word} + sym_elems;
  end

  assign job_valid = s1_valid;

`ifndef NO_ASSERTIONS
  a_total_max : assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job.total <= MAX_ELEMS))
    else $error("job with too many elements");

  a_word_no_symbols : assert property (@(posedge clk) disable iff (rst)
    (job_valid && job.word) |-> (job.len == '0 && !job.letter))
    else $error("space decoded with symbols or letter gap");
`endif

endmodule
`default_nettype wire

[src/mce_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mce_seq: element sequencer and output register
// Steps through one job, one element per cycle while the output is free, and drives the result
// register with kind, light flag, duration and last marker.
// ----------------------------------------------------------------------------
module mce_seq (
  input  wire                       clk,
  input  wire                       rst,
  input  wire  [mce_pkg::DOT_W-1:0] dot_ticks,
  input  wire                       job_valid,
  output logic                      job_ready,
  input  wire  mce_pkg::char_job_t  job,
  output logic                      out_valid,
  input  wire                       out_ready,
  output mce_pkg::elem_kind_t       out_kind,
  output logic                      out_light,
  output logic [mce_pkg::DUR_W-1:0] out_dur,
  output logic                      out_last
);
  import mce_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic             have_letter;
  logic             is_word;
  logic             gap_next;
  logic [LEN_W-1:0] sym_left;
  logic [PAT_W-1:0] pat;
  logic             out_free;
  logic             emit;
  logic             job_take;
  elem_kind_t       kind_sel;
  logic [DUR_W-1:0] d1;
  logic [DUR_W-1:0] dur_sel;

  assign out_free  = !out_valid || out_ready;
  assign emit      = (cnt != '0) && out_free;
  assign job_ready = (cnt == '0) || ((cnt == 4'd1) && emit);
  assign job_take  = job_valid && job_ready;
  assign d1        = {3'b0, dot_ticks};

  // pick the next element and its duration
  always_comb begin
    if (have_letter) begin
      kind_sel = KIND_LETTER;
    end else if (is_word) begin
      kind_sel = KIND_WORD;
    end else if (gap_next) begin
      kind_sel = KIND_INTRA;
    end else if (pat[PAT_W-1]) begin
      kind_sel = KIND_DASH;
    end else begin
      kind_sel = KIND_DOT;
    end
    unique case (kind_sel)
      KIND_DOT, KIND_INTRA:   dur_sel = d1;
      KIND_DASH, KIND_LETTER: dur_sel = (d1 << 1) + d1;
      KIND_WORD:              dur_sel = (d1 << 3) - d1;
      default:                dur_sel = d1;
    endcase
  end

  // advance through the job, load the next one as the last element goes
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (job_take) begin
      cnt <= job.total;
    end else if (emit) begin
      cnt <= cnt - 4'd1;
    end
    if (rst) begin
      have_letter <= 1'b0;
      is_word     <= 1'b0;
      gap_next    <= 1'b0;
      sym_left    <= '0;
    end else if (job_take) begin
      have_letter <= job.letter;
      is_word     <= job.word;
      gap_next    <= 1'b0;
      sym_left    <= job.len;
      pat         <= job.pat;
    end else if (emit) begin
      if (have_letter) begin
        have_letter <= 1'b0;
      end else if (is_word) begin
        is_word <= 1'b0;
      end else if (gap_next) begin
        gap_next <= 1'b0;
      end else begin
        pat      <= pat << 1;
        sym_left <= sym_left - 3'd1;
        gap_next <= (sym_left != 3'd1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
    if (emit) begin
      out_kind  <= kind_sel;
      out_light <= (kind_sel == KIND_DOT) || (kind_sel == KIND_DASH);
      out_dur   <= dur_sel;
      out_last  <= (cnt == 4'd1);
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_max : assert property (@(posedge clk) disable iff (rst)
    cnt <= MAX_ELEMS)
    else $error("element count out of range");

  a_done_clean : assert property (@(posedge clk) disable iff (rst)
    (cnt == '0 && !$past(job_take)) |-> (!have_letter && !is_word && sym_left == '0))
    else $error("job finished with elements left");

  a_light_kind : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_light == (out_kind == KIND_DOT || out_kind == KIND_DASH)))
    else $error("light flag disagrees with element kind");
`endif

endmodule
`default_nettype wire

[src/morse_code_element_encoder_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morse_code_element_encoder_core: character to Morse element stream
// One character per slave-side request (tdata = char_code). Each result on
// the master side is one element: tuser = element_kind and light_on,
// tdata = duration_ticks, tlast marks the final element of a character.
// Lower-case letters, digits, comma and period send dots and dashes with
// intra-letter gaps; a letter gap leads every character but space, CR and
// LF not after a space; space sends a word gap; CR and LF send nothing.
// The cfg channel writes dot_ticks (reset 20); write it only while idle.
// The first element of a character passes the input stage with state RAM
// read, the sequencer and the output register.
// Throughput: one element per cycle while the receiver does not stall; a
// character sends up to 12 elements, and the next character is taken while
// the previous one is still sending.
// Reset clears the after-space flag (a valid bit masks the state RAM until
// its first write) and restores dot_ticks; no clearing pass is needed.
// When the receiver stalls, the output register holds and the pipeline stops.
// ----------------------------------------------------------------------------
module morse_code_element_encoder_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [18:0] duration_ticks, [23:19] zero
  output logic [3:0]  m_axis_tuser,   // [2:0] element_kind, [3] light_on
  output logic        m_axis_tlast,   // last_element
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_data        // dot_ticks
);
  import mce_pkg::*;

  logic [DOT_W-1:0] dot_ticks;
  logic             job_valid;
  logic             job_ready;
  char_job_t        job;
  elem_kind_t       out_kind;
  logic             out_light;
  logic [DUR_W-1:0] out_dur;

  assign cfg_ready = 1'b1;

  // dot length register
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks <= DOT_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dot_ticks <= cfg_data;
    end
  end

  mce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_char   (s_axis_tdata),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  mce_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .dot_ticks (dot_ticks),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (out_kind),
    .out_light (out_light),
    .out_dur   (out_dur),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, out_dur};
  assign m_axis_tuser = {out_light, out_kind};

endmodule
`default_nettype wire
